>>> sv/wtrt_pkg.sv
// ----------------------------------------------------------------------------
// wtrt_pkg
// Shared types, constants and step functions for the wavelength to raw
// threshold pipeline.
// ----------------------------------------------------------------------------
package wtrt_pkg;

	localparam int LAMBDA_BITS = 18;
	localparam int LEFT_LIMIT = 131000;
	localparam int CFG_DATA_W = 40;
	localparam int CFG_IDX_W = 3;
	localparam int RAW_MAX = 16383;

	localparam int SQRT_STAGES = 16;
	localparam int CORDIC_STAGES = 15;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_SAT = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef enum logic [2:0] {
		REG_LEFT_SCALE,
		REG_LEFT_GAIN,
		REG_LEFT_OFFSET,
		REG_RIGHT_SCALE,
		REG_RIGHT_GAIN,
		REG_RIGHT_OFFSET,
		REG_GLOBAL_GAIN,
		REG_GLOBAL_OFFSET
	} reg_idx_t;

	typedef struct packed {
		logic valid;
		logic side;
		logic ovf;
	} ctl_t;

	typedef struct packed {
		logic [60:0] rem;
		logic [61:0] root;
		logic [30:0] y0;
	} sq_t;

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [32:0] z;
	} rot_t;

	function automatic logic signed [32:0] atan_q30(input int i);
		logic signed [32:0] t;
		case (i)
			0: t = 33'sd843314857;
			1: t = 33'sd497837829;
			2: t = 33'sd263043837;
			3: t = 33'sd133525159;
			4: t = 33'sd67021687;
			5: t = 33'sd33543516;
			6: t = 33'sd16775851;
			7: t = 33'sd8388437;
			8: t = 33'sd4194283;
			9: t = 33'sd2097149;
			default: t = 33'sd1 <<< (30 - i);
		endcase
		return t;
	endfunction

	function automatic sq_t sqrt_step(input sq_t s, input int k);
		sq_t o;
		logic [61:0] bit_v;
		logic [61:0] trial;
		o = s;
		bit_v = 62'd1 << (2 * k);
		trial = s.root + bit_v;
		if ({1'b0, s.rem} >= trial) begin
			o.rem = s.rem - trial[60:0];
			o.root = (s.root >> 1) + bit_v;
		end else begin
			o.root = s.root >> 1;
		end
		return o;
	endfunction

	function automatic sq_t sqrt_stage(input sq_t s, input int j);
		sq_t o;
		o = s;
		for (int m = 0; m < 2; m++) begin
			if (30 - 2 * j - m >= 0)
				o = sqrt_step(o, 30 - 2 * j - m);
		end
		return o;
	endfunction

	function automatic rot_t cordic_step(input rot_t s, input int i);
		rot_t o;
		if (!s.y[33]) begin
			o.x = s.x + (s.y >>> i);
			o.y = s.y - (s.x >>> i);
			o.z = s.z + atan_q30(i);
		end else begin
			o.x = s.x - (s.y >>> i);
			o.y = s.y + (s.x >>> i);
			o.z = s.z - atan_q30(i);
		end
		return o;
	endfunction

	function automatic rot_t cordic_stage(input rot_t s, input int j);
		rot_t o;
		o = cordic_step(s, 2 * j);
		o = cordic_step(o, 2 * j + 1);
		return o;
	endfunction

endpackage

>>> sv/wtrt_asin.sv
// ----------------------------------------------------------------------------
// wtrt_asin
// Pipelined arcsine: integer square root for the cosine term, then CORDIC
// vectoring, two steps per stage.
// ----------------------------------------------------------------------------
module wtrt_asin (
	input  logic                  clk,
	input  logic                  arst_n,
	input  wtrt_pkg::ctl_t        in_ctl,
	input  logic [30:0]           y0,
	input  logic [61:0]           ysq,
	output wtrt_pkg::ctl_t        out_ctl,
	output logic signed [32:0]    angle
);

	localparam int NSQ = wtrt_pkg::SQRT_STAGES;
	localparam int NCO = wtrt_pkg::CORDIC_STAGES;
	localparam int NCTL = NSQ + NCO + 1;

	wtrt_pkg::ctl_t ctl_s [NCTL];
	wtrt_pkg::sq_t  sq_s  [NSQ + 1];
	wtrt_pkg::rot_t rot_s [NCO];
	wtrt_pkg::rot_t rot_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else begin
			ctl_s[0] <= in_ctl;
		end
	end

	always_ff @(posedge clk) begin
		sq_s[0].rem <= 61'(62'd1 << 60) - ysq[60:0];
		sq_s[0].root <= '0;
		sq_s[0].y0 <= y0;
	end

	for (genvar j = 1; j < NCTL; j++) begin : g_ctl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[j] <= '0;
			end else begin
				ctl_s[j] <= ctl_s[j - 1];
			end
		end
	end

	for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
		always_ff @(posedge clk) begin
			sq_s[j + 1] <= wtrt_pkg::sqrt_stage(sq_s[j], j);
		end
	end

	always_comb begin
		rot_in.x = {3'b000, sq_s[NSQ].root[30:0]};
		rot_in.y = {3'b000, sq_s[NSQ].y0};
		rot_in.z = '0;
	end

	for (genvar j = 0; j < NCO; j++) begin : g_cordic
		always_ff @(posedge clk) begin
			if (j == 0) begin
				rot_s[j] <= wtrt_pkg::cordic_stage(rot_in, j);
			end else begin
				rot_s[j] <= wtrt_pkg::cordic_stage(rot_s[(j == 0) ? 0 : j - 1], j);
			end
		end
	end

	assign out_ctl = ctl_s[NCTL - 1];
	assign angle = rot_s[NCO - 1].z;

endmodule

>>> sv/wavelength_to_raw_threshold.sv
// ----------------------------------------------------------------------------
// wavelength_to_raw_threshold
// Throughput: one item per cycle; busy stays low, the result is not stalled.
// Pipeline: the 31-step square root and 30-step CORDIC, two steps per stage.
// Reset: asynchronous, clears the valid chain and loads register defaults.
// ----------------------------------------------------------------------------
module wavelength_to_raw_threshold #(
	parameter int LAMBDA_BITS = wtrt_pkg::LAMBDA_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [LAMBDA_BITS-1:0]          wavelength,
	output logic                            done,
	output logic [13:0]                     raw_value,
	output logic [1:0]                      status,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [wtrt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wtrt_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int PW = LAMBDA_BITS + 32;

	logic [31:0]        left_scale_q, right_scale_q;
	logic signed [31:0] left_gain_q, right_gain_q, global_gain_q, global_offset_q;
	logic signed [39:0] left_offset_q, right_offset_q;

	wtrt_pkg::ctl_t     ctl_s1, ctl_s2, asin_ctl, ctl_s3, ctl_s4, ctl_s5;
	logic [PW-1:0]      p_s1;
	logic [30:0]        y0_s2;
	logic [61:0]        ysq_s2;
	logic signed [32:0] angle;
	logic signed [64:0] prod_s3;
	logic signed [40:0] ys_s4;
	logic signed [48:0] hp_s5;
	logic signed [56:0] lp_s5;

	logic               ovf;
	logic [30:0]        y0;
	logic signed [64:0] prod_r;
	logic signed [49:0] acc_a;
	logic signed [57:0] acc_b;
	logic signed [50:0] acc_c;
	logic signed [34:0] c_val;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_scale_q <= '0;
			left_gain_q <= 32'sd65536;
			left_offset_q <= '0;
			right_scale_q <= '0;
			right_gain_q <= 32'sd65536;
			right_offset_q <= '0;
			global_gain_q <= 32'sd16777216;
			global_offset_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (wtrt_pkg::reg_idx_t'(cfg_index))
				wtrt_pkg::REG_LEFT_SCALE:    left_scale_q <= cfg_data[31:0];
				wtrt_pkg::REG_LEFT_GAIN:     left_gain_q <= $signed(cfg_data[31:0]);
				wtrt_pkg::REG_LEFT_OFFSET:   left_offset_q <= $signed(cfg_data[39:0]);
				wtrt_pkg::REG_RIGHT_SCALE:   right_scale_q <= cfg_data[31:0];
				wtrt_pkg::REG_RIGHT_GAIN:    right_gain_q <= $signed(cfg_data[31:0]);
				wtrt_pkg::REG_RIGHT_OFFSET:  right_offset_q <= $signed(cfg_data[39:0]);
				wtrt_pkg::REG_GLOBAL_GAIN:   global_gain_q <= $signed(cfg_data[31:0]);
				wtrt_pkg::REG_GLOBAL_OFFSET: global_offset_q <= $signed(cfg_data[31:0]);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			done <= 1'b0;
		end else begin
			ctl_s1.valid <= start && !busy;
			ctl_s1.side <= 32'(wavelength) > 32'(wtrt_pkg::LEFT_LIMIT);
			ctl_s1.ovf <= 1'b0;
			ctl_s2.valid <= ctl_s1.valid;
			ctl_s2.side <= ctl_s1.side;
			ctl_s2.ovf <= ovf;
			ctl_s3 <= asin_ctl;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			done <= ctl_s5.valid;
		end
	end

	// stage 1: side select and argument product
	always_ff @(posedge clk) begin
		p_s1 <= PW'(wavelength) *
			PW'((32'(wavelength) > 32'(wtrt_pkg::LEFT_LIMIT)) ? right_scale_q : left_scale_q);
	end

	// stage 2: range check and square of the argument
	always_comb begin
		ovf = p_s1 > (PW'(1) << 40);
		y0 = ovf ? '0 : p_s1[40:10];
	end

	always_ff @(posedge clk) begin
		y0_s2 <= y0;
		ysq_s2 <= 62'(y0) * 62'(y0);
	end

	wtrt_asin u_asin (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ctl  (ctl_s2),
		.y0      (y0_s2),
		.ysq     (ysq_s2),
		.out_ctl (asin_ctl),
		.angle   (angle)
	);

	always_ff @(posedge clk) begin
		prod_s3 <= 65'(asin_ctl.side ? right_gain_q : left_gain_q) * 65'(angle);
	end

	always_comb begin
		prod_r = prod_s3 + 65'sd536870912;
	end

	always_ff @(posedge clk) begin
		ys_s4 <= 41'($signed(prod_r[64:30])) +
			41'(ctl_s3.side ? right_offset_q : left_offset_q);
	end

	always_ff @(posedge clk) begin
		hp_s5 <= 49'(global_gain_q) * 49'($signed(ys_s4[40:24]));
		lp_s5 <= 57'(global_gain_q) * 57'($signed({1'b0, ys_s4[23:0]}));
	end

	always_comb begin
		acc_a = 50'(hp_s5) + 50'(global_offset_q);
		acc_b = 58'(lp_s5) + (58'sd1 <<< 39);
		acc_c = 51'(acc_a) + 51'($signed(acc_b[57:24]));
		c_val = acc_c[50:16];
	end

	always_ff @(posedge clk) begin
		if (ctl_s5.ovf) begin
			raw_value <= '0;
			status <= wtrt_pkg::ST_RANGE;
		end else if (c_val[34]) begin
			raw_value <= '0;
			status <= wtrt_pkg::ST_SAT;
		end else if (c_val > 35'(wtrt_pkg::RAW_MAX)) begin
			raw_value <= 14'(wtrt_pkg::RAW_MAX);
			status <= wtrt_pkg::ST_SAT;
		end else begin
			raw_value <= c_val[13:0];
			status <= wtrt_pkg::ST_OK;
		end
	end

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives wavelengths into the raw threshold pipeline under several register
// settings and compares every raw value and status against an in-line
// fixed-point arcsine and calibration predictor.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY_WAIT = 48;
	localparam int CYCLE_LIMIT = 400000;
	localparam longint PI_QUARTER_Q30 = 843314857;

	typedef struct {
		logic [13:0] raw;
		logic [1:0]  st;
	} threshold_t;

	class threshold_board;
		longint unsigned regv[8];
		int              regw[8];
		longint          atan_tab[30];
		threshold_t      pending[$];
		int              errors;
		int              n_items;
		int              n_range;
		int              n_sat;

		function new();
			longint acc;
			longint term;
			int     e;
			regw = '{32, 32, 40, 32, 32, 40, 32, 32};
			regv = '{0, 65536, 0, 0, 65536, 0, 16777216, 0};
			atan_tab[0] = PI_QUARTER_Q30;
			for (int i = 1; i < 30; i++) begin
				acc = 0;
				for (int k = 0; ; k++) begin
					e = i * (2 * k + 1);
					if (e > 60)
						break;
					term = (longint'(1) << (60 - e)) / (2 * k + 1);
					acc += (k % 2) ? -term : term;
				end
				atan_tab[i] = (acc + (longint'(1) << 29)) >>> 30;
			end
		endfunction

		function void set_reg(wtrt_pkg::reg_idx_t r, logic [39:0] d);
			regv[r] = d & ((longint'(1) << regw[r]) - 1);
		endfunction

		function longint sx(longint unsigned v, int w);
			longint t;
			t = longint'(v << (64 - w));
			return t >>> (64 - w);
		endfunction

		function longint unsigned root60(longint unsigned v);
			longint unsigned r;
			longint unsigned b;
			r = 0;
			b = longint'(1) << 62;
			while (b > v)
				b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		function longint arcsine(longint y);
			longint x;
			longint z;
			longint dx;
			longint dy;
			x = longint'(root60((longint'(1) << 60) - y * y));
			z = 0;
			for (int i = 0; i < 30; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (y >= 0) begin
					x += dx; y -= dy; z += atan_tab[i];
				end else begin
					x -= dx; y += dy; z -= atan_tab[i];
				end
			end
			return z;
		endfunction

		function void note(logic [wtrt_pkg::LAMBDA_BITS-1:0] lam);
			int                  base;
			longint unsigned     p;
			longint              a;
			longint              ys;
			logic signed [127:0] acc;
			logic signed [127:0] c;
			threshold_t          t;
			n_items++;
			base = (lam <= wtrt_pkg::LEFT_LIMIT) ? wtrt_pkg::REG_LEFT_SCALE
				: wtrt_pkg::REG_RIGHT_SCALE;
			p = longint'(lam) * regv[base];
			if (p > (longint'(1) << 40)) begin
				t.raw = 0;
				t.st = wtrt_pkg::ST_RANGE;
			end else begin
				a = arcsine(longint'(p >> 10));
				ys = ((sx(regv[base + 1], 32) * a + (longint'(1) << 29)) >>> 30)
					+ sx(regv[base + 2], 40);
				acc = 128'(ys) * 128'(sx(regv[wtrt_pkg::REG_GLOBAL_GAIN], 32))
					+ (128'(sx(regv[wtrt_pkg::REG_GLOBAL_OFFSET], 32)) <<< 24)
					+ (128'sd1 <<< 39);
				c = acc >>> 40;
				if (c < 0) begin
					t.raw = 0;
					t.st = wtrt_pkg::ST_SAT;
				end else if (c > wtrt_pkg::RAW_MAX) begin
					t.raw = wtrt_pkg::RAW_MAX;
					t.st = wtrt_pkg::ST_SAT;
				end else begin
					t.raw = c[13:0];
					t.st = wtrt_pkg::ST_OK;
				end
			end
			pending.push_back(t);
		endfunction

		task report(string what);
			$display("ERROR %0t: %s", $realtime, what);
			errors++;
		endtask

		task check(logic [13:0] raw, logic [1:0] st);
			threshold_t t;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result raw=%0d status=%0d", raw, st));
				return;
			end
			t = pending.pop_front();
			if (st == wtrt_pkg::ST_RANGE)
				n_range++;
			if (st == wtrt_pkg::ST_SAT)
				n_sat++;
			if (raw !== t.raw)
				report($sformatf("raw_value %0d, predicted %0d", raw, t.raw));
			if (st !== t.st)
				report($sformatf("status %0d, predicted %0d", st, t.st));
		endtask
	endclass

	logic                               clk;
	logic                               arst_n;
	logic                               start;
	logic                               busy;
	logic [wtrt_pkg::LAMBDA_BITS-1:0]   wavelength;
	logic                               done;
	logic [13:0]                        raw_value;
	logic [1:0]                         status;
	logic                               cfg_valid;
	logic                               cfg_ready;
	logic [wtrt_pkg::CFG_IDX_W-1:0]     cfg_index;
	logic [wtrt_pkg::CFG_DATA_W-1:0]    cfg_data;

	threshold_board board = new();
	int cycles = 0;
	int idle_pct = 0;

	wavelength_to_raw_threshold i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.wavelength(wavelength), .done(done), .raw_value(raw_value),
		.status(status), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
		if (arst_n) begin
			if (start && !busy)
				board.note(wavelength);
			if (done)
				board.check(raw_value, status);
		end
	end

	task write_reg(wtrt_pkg::reg_idx_t r, logic [39:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(r, d);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task write_all(logic [39:0] ls, logic [39:0] lg, logic [39:0] lo, logic [39:0] rs,
			logic [39:0] rg, logic [39:0] ro, logic [39:0] gg, logic [39:0] go);
		write_reg(wtrt_pkg::REG_LEFT_SCALE, ls);
		write_reg(wtrt_pkg::REG_LEFT_GAIN, lg);
		write_reg(wtrt_pkg::REG_LEFT_OFFSET, lo);
		write_reg(wtrt_pkg::REG_RIGHT_SCALE, rs);
		write_reg(wtrt_pkg::REG_RIGHT_GAIN, rg);
		write_reg(wtrt_pkg::REG_RIGHT_OFFSET, ro);
		write_reg(wtrt_pkg::REG_GLOBAL_GAIN, gg);
		write_reg(wtrt_pkg::REG_GLOBAL_OFFSET, go);
	endtask

	task send(logic [wtrt_pkg::LAMBDA_BITS-1:0] lam);
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		wavelength <= lam;
		do @(posedge clk); while (busy);
	endtask

	// hold off until every pending result has arrived
	task drain();
		start <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY_WAIT) @(posedge clk);
	endtask

	task random_config(logic wide);
		logic [39:0] hi;
		hi = wide ? {8'($urandom), 32'h0} : 40'h0;
		write_all(hi | $urandom_range(4000000, 9000000),
			hi | (40'($urandom_range(0, 12000)) << 16),
			{$urandom_range(0, 255) > 127 ? 8'hFF : 8'h00, 32'($urandom_range(0, 1 << 28))},
			hi | $urandom_range(2000000, 4400000),
			hi | (40'($urandom_range(0, 12000)) << 16),
			40'($signed(32'($urandom_range(0, 1 << 26)) - 32'(1 << 25))),
			hi | $urandom_range(1 << 22, 1 << 25),
			hi | 40'($signed(32'($urandom_range(0, 1 << 24)) - 32'(1 << 23))));
	endtask

	task random_items(int n);
		for (int i = 0; i < n; i++)
			send(18'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		wavelength = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 13;
		send(18'd0);
		send(18'd262143);
		send(18'd131000);
		drain();

		// exact unit arguments land on both sides
		write_all(40'd16777216, 40'd655360000, 40'd0, 40'd8388608,
			40'd655360000, 40'd0, 40'd16777216, 40'd0);
		send(18'd0);
		send(18'd1);
		send(18'd65536);
		send(18'd65537);
		send(18'd131000);
		send(18'd131001);
		send(18'd131072);
		send(18'd131073);
		send(18'd262143);
		send(18'h2AAAA);
		send(18'h15555);
		drain();
		write_reg(wtrt_pkg::REG_GLOBAL_OFFSET, 40'h7FFF_FFFF);
		send(18'd1000);
		drain();
		write_reg(wtrt_pkg::REG_GLOBAL_OFFSET, 40'h8000_0000);
		send(18'd1000);
		drain();

		random_config(1'b0);
		random_items(200);
		drain();
		random_items(200);
		drain();
		write_all(40'hFFFF_FFFF, 40'h7FFF_FFFF, 40'h7F_FFFF_FFFF, 40'hFFFF_FFFF,
			40'h7FFF_FFFF, 40'h7F_FFFF_FFFF, 40'h7FFF_FFFF, 40'h7FFF_FFFF);
		random_items(50);
		drain();

		idle_pct = 70;
		write_all(40'd1, 40'h8000_0000, 40'h80_0000_0000, 40'd0,
			40'h8000_0000, 40'h80_0000_0000, 40'h8000_0000, 40'h8000_0000);
		random_items(50);
		drain();
		random_config(1'b0);
		random_items(400);
		drain();

		idle_pct = 0;
		random_config(1'b1);
		random_items(300);
		drain();

		$display("Covered %0d wavelengths: %0d out of range, %0d saturated.",
			board.n_items, board.n_range, board.n_sat);
		if (board.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
